/* hdl/fbsr_pkg.sv */
// Package for the frame-store shape rasterizer: command codes, the queued
// command record, queue status and the back-end state encoding.
// No dependencies; every other file of the block but fbsr_ram refers to it.
`default_nettype none

package fbsr_pkg;

   // Command codes as they arrive on the request channel.
   localparam logic [2:0] KIND_PUT          = 3'd0;
   localparam logic [2:0] KIND_CLEAR        = 3'd1;
   localparam logic [2:0] KIND_RECT_EDGE    = 3'd2;
   localparam logic [2:0] KIND_RECT_FILL    = 3'd3;
   localparam logic [2:0] KIND_CIRCLE_EDGE  = 3'd4;
   localparam logic [2:0] KIND_CIRCLE_FILL  = 3'd5;
   localparam logic [2:0] KIND_READ         = 3'd6;

   localparam int COORD_W     = 11;
   localparam int RADIUS_W    = 9;
   localparam int COLOR_W     = 24;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_BOX,
      OP_RECT_EDGE,
      OP_CIRCLE_EDGE,
      OP_CIRCLE_FILL,
      OP_CLEAR,
      OP_READ
   } op_type;

   // Bounding box corners are inclusive and may lie left of or above the store.
   typedef struct packed {
      op_type                      op;
      logic signed [COORD_W-1:0]   x0;
      logic signed [COORD_W-1:0]   y0;
      logic signed [COORD_W-1:0]   x1;
      logic signed [COORD_W-1:0]   y1;
      logic [RADIUS_W-1:0]         radius;
      logic [COLOR_W-1:0]          color;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SETUP,
      B_PREP,
      B_REDUCE,
      B_SCAN,
      B_CLEAR,
      B_READ,
      B_READ_WAIT
   } back_state_type;

endpackage

`default_nettype wire

/* hdl/fbsr_if.sv */
// Channel interfaces of the rasterizer: the command request channel and the
// read response channel, each with valid/ready handshake. Uses fbsr_pkg.
`default_nettype none

interface fbsr_req_if;
   logic                         valid;
   logic                         ready;
   logic [2:0]                   kind;
   logic [8:0]                   pos_x;
   logic [7:0]                   pos_y;
   logic [8:0]                   extent_a;
   logic [7:0]                   extent_b;
   logic [fbsr_pkg::COLOR_W-1:0] pixel_color;

   modport source (output valid, output kind, output pos_x, output pos_y,
                   output extent_a, output extent_b, output pixel_color,
                   input ready);
   modport sink (input valid, input kind, input pos_x, input pos_y,
                 input extent_a, input extent_b, input pixel_color,
                 output ready);
endinterface

interface fbsr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fbsr_pkg::COLOR_W-1:0] read_color;

   modport source (output valid, output read_color, input ready);
   modport sink (input valid, input read_color, output ready);
endinterface

`default_nettype wire

/* hdl/framebuffer_shape_rasterizer.sv */
// Top level of the frame-store shape rasterizer: front end, command queue,
// back end and the frame store RAM. Uses fbsr_pkg, fbsr_if and all submodules.
//
//   channel   dir   beat contents
//   req_chan  in    kind, pos_x, pos_y, extent_a, extent_b, pixel_color
//   rsp_chan  out   read_color (read commands only)
//
// A shape or put command passes setup, preparation, the R subtract steps of
// the start-address reduction (3 at 320 x 200) and a scan of its box in the
// back end; one pixel per cycle is set by the single store write port. A
// read takes the same steps up to the reduction; a clear zeroes every address.
// Reset clears the control state only; the store holds nothing defined until
// written. A two-entry queue keeps the request side open while a command is
// drawn, and a full response register holds back only the next read.
`default_nettype none

module framebuffer_shape_rasterizer #(
   parameter int FB_WIDTH  = 320,
   parameter int FB_HEIGHT = 200
) (
   input  wire logic  clock,
   input  wire logic  reset,
   fbsr_req_if.sink   req_chan,
   fbsr_rsp_if.source rsp_chan
);

   localparam int StoreSize = FB_WIDTH * FB_HEIGHT;
   localparam int AddrW     = $clog2(StoreSize);

   fbsr_pkg::cmd_type          push_cmd;
   fbsr_pkg::cmd_type          head;
   fbsr_pkg::queue_status_type qstat;
   logic                       push;
   logic                       pop;
   logic                       ram_we;
   logic [AddrW-1:0]           ram_waddr;
   logic [AddrW-1:0]           ram_raddr;
   logic [fbsr_pkg::COLOR_W-1:0] ram_wdata;
   logic [fbsr_pkg::COLOR_W-1:0] ram_rdata;

   fbsr_front u_front (
      .req_chan (req_chan),
      .qstat    (qstat),
      .push     (push),
      .cmd      (push_cmd)
   );

   fbsr_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   fbsr_back #(
      .FB_WIDTH  (FB_WIDTH),
      .FB_HEIGHT (FB_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rsp_chan  (rsp_chan)
   );

   fbsr_ram #(
      .DATA_W (fbsr_pkg::COLOR_W),
      .DEPTH  (StoreSize)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

`default_nettype wire

/* hdl/fbsr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module fbsr_ram #(
   parameter int DATA_W = 24,
   parameter int DEPTH  = 64000,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/fbsr_front.sv */
// Front end: accepts request beats and turns each command into a bounding
// box record for the command queue. Uses fbsr_pkg and fbsr_req_if.
`default_nettype none

module fbsr_front (
   fbsr_req_if.sink                          req_chan,
   input  wire fbsr_pkg::queue_status_type   qstat,
   output logic                              push,
   output fbsr_pkg::cmd_type                 cmd
);

   logic                               keep;
   logic signed [fbsr_pkg::COORD_W-1:0] px;
   logic signed [fbsr_pkg::COORD_W-1:0] py;
   logic signed [fbsr_pkg::COORD_W-1:0] ea;
   logic signed [fbsr_pkg::COORD_W-1:0] eb;

   assign px = $signed({2'b00, req_chan.pos_x});
   assign py = $signed({3'b000, req_chan.pos_y});
   assign ea = $signed({2'b00, req_chan.extent_a});
   assign eb = $signed({3'b000, req_chan.extent_b});

   assign req_chan.ready = !qstat.full;

   always_comb begin
      keep       = 1'b1;
      cmd.op     = fbsr_pkg::OP_BOX;
      cmd.x0     = px;
      cmd.y0     = py;
      cmd.x1     = px;
      cmd.y1     = py;
      cmd.radius = '0;
      cmd.color  = req_chan.pixel_color;
      unique case (req_chan.kind) inside
         fbsr_pkg::KIND_PUT: begin
            cmd.op = fbsr_pkg::OP_BOX;
         end
         fbsr_pkg::KIND_CLEAR: begin
            cmd.op = fbsr_pkg::OP_CLEAR;
         end
         fbsr_pkg::KIND_RECT_EDGE, fbsr_pkg::KIND_RECT_FILL: begin
            cmd.op = (req_chan.kind == fbsr_pkg::KIND_RECT_EDGE) ?
                     fbsr_pkg::OP_RECT_EDGE : fbsr_pkg::OP_BOX;
            cmd.x1 = px + ea;
            cmd.y1 = py + eb;
         end
         fbsr_pkg::KIND_CIRCLE_EDGE, fbsr_pkg::KIND_CIRCLE_FILL: begin
            cmd.op = (req_chan.kind == fbsr_pkg::KIND_CIRCLE_EDGE) ?
                     fbsr_pkg::OP_CIRCLE_EDGE : fbsr_pkg::OP_CIRCLE_FILL;
            cmd.x0     = px - ea;
            cmd.y0     = py - ea;
            cmd.x1     = px + ea;
            cmd.y1     = py + ea;
            cmd.radius = req_chan.extent_a;
         end
         fbsr_pkg::KIND_READ: begin
            cmd.op = fbsr_pkg::OP_READ;
         end
         default: begin
            // The spare code is accepted and dropped.
            keep = 1'b0;
         end
      endcase
   end

   assign push = req_chan.valid && req_chan.ready && keep;

endmodule

`default_nettype wire

/* hdl/fbsr_cmd_queue.sv */
// Short command queue between the front end and the back end.
// Uses fbsr_pkg for the command record and the status struct.
`default_nettype none

module fbsr_cmd_queue (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire fbsr_pkg::cmd_type            push_cmd,
   input  wire logic                         pop,
   output fbsr_pkg::cmd_type                 head,
   output fbsr_pkg::queue_status_type        qstat
);

   fbsr_pkg::cmd_type                mem_ff [fbsr_pkg::QUEUE_DEPTH];
   logic [fbsr_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [fbsr_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [fbsr_pkg::QCNT_W-1:0]      count_ff, count_in;

   localparam logic [fbsr_pkg::QPTR_W-1:0] LastPtr =
      fbsr_pkg::QPTR_W'(fbsr_pkg::QUEUE_DEPTH - 1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head        = mem_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == fbsr_pkg::QCNT_W'(fbsr_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

endmodule

`default_nettype wire

/* hdl/fbsr_back.sv */
// Back end: takes commands from the queue, reduces the start address modulo
// the store size, then scans the bounding box one pixel per cycle, clears the
// store or reads one pixel. Uses fbsr_pkg and fbsr_rsp_if.
`default_nettype none

module fbsr_back #(
   parameter int FB_WIDTH  = 320,
   parameter int FB_HEIGHT = 200,
   localparam int STORE_SIZE = FB_WIDTH * FB_HEIGHT,
   localparam int ADDR_W     = $clog2(STORE_SIZE)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire fbsr_pkg::cmd_type           head,
   input  wire fbsr_pkg::queue_status_type  qstat,
   output logic                             pop,
   output logic                             ram_we,
   output logic [ADDR_W-1:0]                ram_waddr,
   output logic [fbsr_pkg::COLOR_W-1:0]     ram_wdata,
   output logic [ADDR_W-1:0]                ram_raddr,
   input  wire logic [fbsr_pkg::COLOR_W-1:0] ram_rdata,
   fbsr_rsp_if.source                       rsp_chan
);

   // Largest and most negative linear position a bounding box can reach.
   localparam int MaxPos  = 1022 + 766 * FB_WIDTH;
   localparam int MaxNeg  = 511 + 511 * FB_WIDTH;
   localparam int LinW    = $clog2(MaxPos + 1) + 1;
   // Multiple of the store size that makes every start position non-negative.
   localparam int Offset  = STORE_SIZE * (MaxNeg / STORE_SIZE + 1);
   localparam int NW      = $clog2(MaxPos + Offset + 1);
   // The offset start position is only a few store sizes large, so a short
   // run of compare-and-subtract steps with halving multiples leaves the
   // remainder.
   localparam int RedSteps = $clog2((MaxPos + Offset) / STORE_SIZE + 1);
   localparam int CntW    = $clog2(RedSteps + 1);
   localparam int CW      = fbsr_pkg::COORD_W;

   localparam logic signed [LinW-1:0] WidthS    = LinW'(FB_WIDTH);
   localparam logic [ADDR_W:0]        StoreX    = (ADDR_W + 1)'(STORE_SIZE);
   localparam logic [ADDR_W:0]        WidthX    = (ADDR_W + 1)'(FB_WIDTH);
   localparam logic [ADDR_W-1:0]      LastAddr  = ADDR_W'(STORE_SIZE - 1);
   localparam logic [NW-1:0]          SubTop    = NW'(STORE_SIZE << (RedSteps - 1));
   localparam logic [CntW-1:0]        LastCnt   = CntW'(RedSteps - 1);

   fbsr_pkg::back_state_type state_ff, state_in;
   fbsr_pkg::cmd_type        cmd_ff, cmd_in;

   logic signed [LinW-1:0]  prod_ff, prod_in;
   logic signed [LinW-1:0]  lin_ff, lin_in;
   logic signed [LinW-1:0]  row_lin_ff, row_lin_in;
   logic [NW-1:0]           n_ff, n_in;
   logic [NW-1:0]           sub_ff, sub_in;
   logic [CntW-1:0]         cnt_ff, cnt_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [ADDR_W-1:0]       row_addr_ff, row_addr_in;
   logic signed [CW-1:0]    col_ff, col_in;
   logic signed [CW-1:0]    row_ff, row_in;
   logic signed [CW-1:0]    dx_ff, dx_in;
   logic signed [CW-1:0]    dy_ff, dy_in;
   logic [17:0]             sqx_ff, sqx_in;
   logic [17:0]             sqy_ff, sqy_in;
   logic [17:0]             inner_ff, inner_in;
   logic [18:0]             outer_ff, outer_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [fbsr_pkg::COLOR_W-1:0] rsp_color_ff, rsp_color_in;

   logic signed [LinW-1:0]  lin0;
   logic signed [NW:0]      n_sum;
   logic [NW-1:0]           n_step;
   logic [ADDR_W:0]         row_addr_sum;
   logic [ADDR_W-1:0]       row_addr_next;
   logic [ADDR_W-1:0]       addr_inc;
   logic signed [19:0]      sqx_t;
   logic signed [19:0]      sqy_t;
   logic [18:0]             d2;
   logic                    col_last;
   logic                    row_last;
   logic                    mark;
   logic                    plot;

   assign lin0  = LinW'($signed(cmd_ff.x0)) + prod_ff;
   assign n_sum = (NW + 1)'(lin0) + (NW + 1)'(Offset);

   assign n_step = (n_ff >= sub_ff) ? n_ff - sub_ff : n_ff;

   assign row_addr_sum  = {1'b0, row_addr_ff} + WidthX;
   assign row_addr_next = (row_addr_sum >= StoreX) ? ADDR_W'(row_addr_sum - StoreX)
                                                   : row_addr_sum[ADDR_W-1:0];
   assign addr_inc      = (addr_ff == LastAddr) ? '0 : addr_ff + 1'b1;

   // (d - 1)^2 = d^2 - 2d + 1 as the distance to the centre steps down.
   assign sqx_t = $signed({2'b00, sqx_ff}) - (20'(dx_ff) <<< 1) + 20'sd1;
   assign sqy_t = $signed({2'b00, sqy_ff}) - (20'(dy_ff) <<< 1) + 20'sd1;
   assign d2    = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   assign col_last = (col_ff == cmd_ff.x1);
   assign row_last = (row_ff == cmd_ff.y1);

   always_comb begin
      case (cmd_ff.op)
         fbsr_pkg::OP_BOX:         mark = 1'b1;
         fbsr_pkg::OP_RECT_EDGE:   mark = (row_ff == cmd_ff.y0) || row_last ||
                                          (col_ff == cmd_ff.x0) || col_last;
         fbsr_pkg::OP_CIRCLE_EDGE: mark = (d2 < outer_ff) && (d2 >= {1'b0, inner_ff});
         fbsr_pkg::OP_CIRCLE_FILL: mark = (d2 < outer_ff);
         default:                  mark = 1'b0;
      endcase
   end

   // Pixels at a negative linear position are skipped.
   assign plot = mark && !lin_ff[LinW-1];

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      prod_in      = prod_ff;
      lin_in       = lin_ff;
      row_lin_in   = row_lin_ff;
      n_in         = n_ff;
      sub_in       = sub_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      row_addr_in  = row_addr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      inner_in     = inner_ff;
      outer_in     = outer_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_color_in = rsp_color_ff;
      pop          = 1'b0;
      ram_we       = 1'b0;
      ram_wdata    = cmd_ff.color;

      unique case (state_ff)
         fbsr_pkg::B_IDLE: begin
            if (!qstat.empty) begin
               pop    = 1'b1;
               cmd_in = head;
               if (head.op == fbsr_pkg::OP_CLEAR) begin
                  addr_in  = '0;
                  state_in = fbsr_pkg::B_CLEAR;
               end else begin
                  state_in = fbsr_pkg::B_SETUP;
               end
            end
         end
         fbsr_pkg::B_SETUP: begin
            prod_in  = LinW'($signed(cmd_ff.y0)) * WidthS;
            inner_in = 18'(cmd_ff.radius) * 18'(cmd_ff.radius);
            state_in = fbsr_pkg::B_PREP;
         end
         fbsr_pkg::B_PREP: begin
            lin_in     = lin0;
            row_lin_in = lin0;
            n_in       = n_sum[NW-1:0];
            sub_in     = SubTop;
            cnt_in     = '0;
            outer_in   = {1'b0, inner_ff} + 19'({cmd_ff.radius, 1'b0}) + 19'd1;
            col_in     = cmd_ff.x0;
            row_in     = cmd_ff.y0;
            dx_in      = $signed({2'b00, cmd_ff.radius});
            dy_in      = $signed({2'b00, cmd_ff.radius});
            sqx_in     = inner_ff;
            sqy_in     = inner_ff;
            state_in   = fbsr_pkg::B_REDUCE;
         end
         fbsr_pkg::B_REDUCE: begin
            n_in   = n_step;
            sub_in = sub_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastCnt) begin
               addr_in     = n_step[ADDR_W-1:0];
               row_addr_in = n_step[ADDR_W-1:0];
               state_in    = (cmd_ff.op == fbsr_pkg::OP_READ) ? fbsr_pkg::B_READ
                                                              : fbsr_pkg::B_SCAN;
            end
         end
         fbsr_pkg::B_SCAN: begin
            ram_we = plot;
            if (col_last) begin
               if (row_last) begin
                  state_in = fbsr_pkg::B_IDLE;
               end else begin
                  row_in      = row_ff + 1'b1;
                  col_in      = cmd_ff.x0;
                  dx_in       = $signed({2'b00, cmd_ff.radius});
                  sqx_in      = inner_ff;
                  dy_in       = dy_ff - 1'b1;
                  sqy_in      = sqy_t[17:0];
                  row_lin_in  = row_lin_ff + WidthS;
                  lin_in      = row_lin_ff + WidthS;
                  row_addr_in = row_addr_next;
                  addr_in     = row_addr_next;
               end
            end else begin
               col_in  = col_ff + 1'b1;
               dx_in   = dx_ff - 1'b1;
               sqx_in  = sqx_t[17:0];
               lin_in  = lin_ff + 1'b1;
               addr_in = addr_inc;
            end
         end
         fbsr_pkg::B_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            if (addr_ff == LastAddr) begin
               state_in = fbsr_pkg::B_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         fbsr_pkg::B_READ: begin
            // The output register is free next cycle, when the data arrives.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = fbsr_pkg::B_READ_WAIT;
            end
         end
         fbsr_pkg::B_READ_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_color_in = ram_rdata;
            state_in     = fbsr_pkg::B_IDLE;
         end
         default: begin
            state_in = fbsr_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbsr_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      prod_ff      <= prod_in;
      lin_ff       <= lin_in;
      row_lin_ff   <= row_lin_in;
      n_ff         <= n_in;
      sub_ff       <= sub_in;
      cnt_ff       <= cnt_in;
      addr_ff      <= addr_in;
      row_addr_ff  <= row_addr_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      inner_ff     <= inner_in;
      outer_ff     <= outer_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign ram_waddr           = addr_ff;
   assign ram_raddr           = addr_ff;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_color = rsp_color_ff;

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == fbsr_pkg::B_SCAN || state_ff == fbsr_pkg::B_CLEAR))
      else $error("store written outside a scan or clear");

   a_write_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ({1'b0, ram_waddr} < StoreX))
      else $error("store write address beyond the store");

   a_wait_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbsr_pkg::B_READ_WAIT) |-> !rsp_valid_ff)
      else $error("read data arrived while the response register was full");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == fbsr_pkg::B_READ_WAIT))
      else $error("response raised without a read");

endmodule

`default_nettype wire
